>>> hdl/dmacc_pkg.sv
// dmacc_pkg: shared types, codes and constants of the dma channel controller
// no dependencies
package dmacc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W = 3;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_DMAEN = 3'd2;
    localparam logic [2:0] OP_HDMAEN = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_XFER  = 2'd2;
    localparam logic [1:0] KIND_IDLE  = 2'd3;

    localparam logic [15:0] ADDR_MDMAEN  = 16'h420b;
    localparam logic [15:0] ADDR_HDMAEN  = 16'h420c;
    localparam logic [15:0] ADDR_DMAREGS = 16'h4380;
    localparam logic [15:0] ADDR_PPU_END = 16'h2200;
    localparam logic [15:0] ADDR_WRAM_END = 16'h2000;
    localparam logic [7:0]  BANK_WRAM    = 8'h7e;
    localparam logic [7:0]  B_VRAM_DATA  = 8'h18;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] reg_addr;
        logic [7:0] write_data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  read_data;
        logic        unmapped_rd;
        logic [2:0]  channel_num;
        logic [15:0] a_address;
        logic [7:0]  a_bank_out;
        logic [7:0]  b_address;
        logic        b_to_a;
        logic        a_side_valid;
        logic        b_side_valid;
        logic        video_port;
        logic        channel_done;
    } res_t;

    function automatic logic [1:0] b_offset(input logic [2:0] mode, input logic [1:0] pi);
        logic [1:0] r;
        r = 2'd0;
        case (mode)
            3'd1, 3'd5: r = {1'b0, pi[0]};
            3'd3, 3'd7: r = {1'b0, pi[1]};
            3'd4:       r = pi;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic sys_bank(input logic [7:0] bank);
        return (bank < 8'h40) || (bank >= 8'h80 && bank < 8'hc0);
    endfunction

endpackage

>>> hdl/dma_channel_controller_top.sv
// dma_channel_controller_top: eight-channel dma controller top level
// depends on dmacc_pkg, dmacc_front, dmacc_back
//
// channel | dir | tuser              | tdata (low bit first)
// s_      | in  | operation[2:0]     | reg_addr[6:0] write_data[14:7]
// m_      | out | result_kind[1:0]   | read_data unmapped_rd channel_num a_address
//         |     |                    | a_bank_out b_address b_to_a a_side_valid
//         |     |                    | b_side_valid video_port channel_done
//
// one beat per cycle while the output is not stalled; each beat runs in the back end
// a beat is queued, run when the back end pops it, and its result is registered
// the two-entry queue lets the input take beats while a result waits
// output stall holds the result register and backs up the queue
// aresetn clears all channel registers to their reset values at once
module dma_channel_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // operation
    input  logic [15:0] s_tdata,   // reg_addr, write_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // result_kind
    output logic [55:0] m_tdata    // read_data .. channel_done, see table
);
    dmacc_pkg::cmd_t cin, qc;
    dmacc_pkg::res_t res;
    logic qv, qr;
    logic unused_pad;

    assign cin.op         = s_tuser;
    assign cin.reg_addr   = s_tdata[6:0];
    assign cin.write_data = s_tdata[14:7];
    assign unused_pad     = s_tdata[15];

    dmacc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(cin),
        .q_valid(qv), .q_ready(qr), .q_cmd(qc)
    );

    dmacc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(qv), .q_ready(qr), .q_cmd(qc),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tuser = res.result_kind;
    assign m_tdata = {7'd0, res.channel_done, res.video_port, res.b_side_valid,
                      res.a_side_valid, res.b_to_a, res.b_address, res.a_bank_out,
                      res.a_address, res.channel_num, res.unmapped_rd, res.read_data};
endmodule

>>> hdl/dmacc_front.sv
// dmacc_front: two-entry command queue on the input side
// depends on dmacc_pkg
module dmacc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  dmacc_pkg::cmd_t in_cmd,
    output logic            q_valid,
    input  logic            q_ready,
    output dmacc_pkg::cmd_t q_cmd
);
    dmacc_pkg::cmd_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_cmd;
        end
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> hdl/dmacc_back.sv
// dmacc_back: channel register file, transfer engine and output register
// depends on dmacc_pkg
module dmacc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  dmacc_pkg::cmd_t q_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output dmacc_pkg::res_t out_res
);
    localparam int N = dmacc_pkg::CHANNELS;

    logic [2:0]  mode_reg   [N];
    logic [4:0]  flags_reg  [N];
    logic [7:0]  bbase_reg  [N];
    logic [15:0] aptr_reg   [N];
    logic [7:0]  abank_reg  [N];
    logic [15:0] count_reg  [N];
    logic [7:0]  ibank_reg  [N];
    logic [15:0] tptr_reg   [N];
    logic [7:0]  rep_reg    [N];
    logic [7:0]  spare_reg  [N];
    logic [7:0]  armed_reg;
    logic [7:0]  harmed_reg;
    logic [1:0]  pidx_reg;
    logic        ov_reg;
    dmacc_pkg::res_t res_reg;

    logic [2:0]  ch;
    logic [3:0]  idx;
    logic        ch_ok, fire, found;
    logic [2:0]  sel;
    logic [7:0]  cmask;
    dmacc_pkg::res_t r;
    logic [15:0] aa, cnt_dec;
    logic [7:0]  bank, ba, rv;
    logic [4:0]  fl;
    logic        va, vb;

    assign cmask = 8'((9'd1 << N) - 9'd1);
    assign q_ready  = !ov_reg || out_ready;
    assign fire     = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign ch  = q_cmd.reg_addr[6:4];
    assign idx = q_cmd.reg_addr[3:0];
    assign ch_ok = ({1'b0, ch} < 4'(N));

    always_comb begin
        found = 1'b0;
        sel = 3'd0;
        for (int i = N - 1; i >= 0; i--) begin
            if (armed_reg[i]) begin
                found = 1'b1;
                sel = 3'(i);
            end
        end
    end

    assign fl   = flags_reg[sel];
    assign aa   = aptr_reg[sel];
    assign bank = abank_reg[sel];
    assign ba   = bbase_reg[sel] + {6'd0, dmacc_pkg::b_offset(mode_reg[sel], pidx_reg)};
    assign cnt_dec = count_reg[sel] - 16'd1;
    assign va = !(dmacc_pkg::sys_bank(bank) &&
                  (aa == dmacc_pkg::ADDR_MDMAEN || aa == dmacc_pkg::ADDR_HDMAEN ||
                   (aa >= 16'h4300 && aa < dmacc_pkg::ADDR_DMAREGS) ||
                   (aa >= 16'h2100 && aa < dmacc_pkg::ADDR_PPU_END)));
    assign vb = !(ba == 8'h80 &&
                  (bank == dmacc_pkg::BANK_WRAM || bank == 8'h7f ||
                   (dmacc_pkg::sys_bank(bank) && aa < dmacc_pkg::ADDR_WRAM_END)));

    always_comb begin
        rv = 8'd0;
        unique case (idx)
            4'h0: rv = {flags_reg[ch], mode_reg[ch]};
            4'h1: rv = bbase_reg[ch];
            4'h2: rv = aptr_reg[ch][7:0];
            4'h3: rv = aptr_reg[ch][15:8];
            4'h4: rv = abank_reg[ch];
            4'h5: rv = count_reg[ch][7:0];
            4'h6: rv = count_reg[ch][15:8];
            4'h7: rv = ibank_reg[ch];
            4'h8: rv = tptr_reg[ch][7:0];
            4'h9: rv = tptr_reg[ch][15:8];
            4'ha: rv = rep_reg[ch];
            4'hb, 4'hf: rv = spare_reg[ch];
            default: rv = 8'd0;
        endcase
    end

    always_comb begin
        r = '0;
        unique case (q_cmd.op)
            dmacc_pkg::OP_READ: begin
                r.result_kind = dmacc_pkg::KIND_READ;
                if (!ch_ok || idx inside {4'hc, 4'hd, 4'he}) r.unmapped_rd = 1'b1;
                else r.read_data = rv;
            end
            dmacc_pkg::OP_STEP: begin
                if (!found) begin
                    r.result_kind = dmacc_pkg::KIND_IDLE;
                end else begin
                    r.result_kind  = dmacc_pkg::KIND_XFER;
                    r.channel_num  = sel;
                    r.a_address    = aa;
                    r.a_bank_out   = bank;
                    r.b_address    = ba;
                    r.b_to_a       = fl[4];
                    r.a_side_valid = va;
                    r.b_side_valid = vb;
                    r.video_port   = (fl[4] ? va : vb) &&
                        (ba == dmacc_pkg::B_VRAM_DATA || ba == 8'h19 ||
                         ba == 8'h04 || ba == 8'h22);
                    r.channel_done = (cnt_dec == 16'd0);
                end
            end
            default: r.result_kind = dmacc_pkg::KIND_ACK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                mode_reg[i]  <= 3'd7;
                flags_reg[i] <= 5'h1f;
                bbase_reg[i] <= 8'hff;
                aptr_reg[i]  <= 16'hffff;
                abank_reg[i] <= 8'hff;
                count_reg[i] <= 16'hffff;
                ibank_reg[i] <= 8'hff;
                tptr_reg[i]  <= 16'hffff;
                rep_reg[i]   <= 8'hff;
                spare_reg[i] <= 8'hff;
            end
            armed_reg  <= 8'd0;
            harmed_reg <= 8'd0;
            pidx_reg   <= 2'd0;
            ov_reg     <= 1'b0;
        end else begin
            if (out_ready && !fire) ov_reg <= 1'b0;
            if (fire) begin
                ov_reg  <= 1'b1;
                res_reg <= r;
                case (q_cmd.op)
                    dmacc_pkg::OP_WRITE: begin
                        if (ch_ok) begin
                            case (idx)
                                4'h0: begin
                                    mode_reg[ch]  <= q_cmd.write_data[2:0];
                                    flags_reg[ch] <= q_cmd.write_data[7:3];
                                end
                                4'h1: bbase_reg[ch] <= q_cmd.write_data;
                                4'h2: aptr_reg[ch][7:0] <= q_cmd.write_data;
                                4'h3: aptr_reg[ch][15:8] <= q_cmd.write_data;
                                4'h4: abank_reg[ch] <= q_cmd.write_data;
                                4'h5: count_reg[ch][7:0] <= q_cmd.write_data;
                                4'h6: count_reg[ch][15:8] <= q_cmd.write_data;
                                4'h7: ibank_reg[ch] <= q_cmd.write_data;
                                4'h8: tptr_reg[ch][7:0] <= q_cmd.write_data;
                                4'h9: tptr_reg[ch][15:8] <= q_cmd.write_data;
                                4'ha: rep_reg[ch] <= q_cmd.write_data;
                                4'hb, 4'hf: spare_reg[ch] <= q_cmd.write_data;
                                default: ;
                            endcase
                        end
                    end
                    dmacc_pkg::OP_DMAEN: begin
                        armed_reg <= q_cmd.write_data & cmask;
                        pidx_reg  <= 2'd0;
                    end
                    dmacc_pkg::OP_HDMAEN: harmed_reg <= q_cmd.write_data & cmask;
                    dmacc_pkg::OP_STEP: begin
                        if (found) begin
                            if (!fl[0]) aptr_reg[sel] <= fl[1] ? aa - 16'd1 : aa + 16'd1;
                            count_reg[sel] <= cnt_dec;
                            if (cnt_dec == 16'd0) begin
                                armed_reg[sel] <= 1'b0;
                                pidx_reg <= 2'd0;
                            end else begin
                                pidx_reg <= pidx_reg + 2'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    logic unused_ok;
    assign unused_ok = ^harmed_reg;
endmodule

>>> dv/tb_dma_channel_controller_top.sv
// tb_dma_channel_controller_top: stream-level test of the dma channel controller
// depends on dmacc_pkg and dma_channel_controller_top; self-checking with an in-bench predictor
`timescale 1ns / 100ps
module tb_dma_channel_controller_top;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [2:0] s_tuser = '0;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [1:0] m_tuser;
    logic [55:0] m_tdata;

    dma_channel_controller_top dut (.*);

    always #4 aclk = ~aclk;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] rdata;
        logic obus;
        logic [2:0] ch;
        logic [15:0] aaddr;
        logic [7:0] abank;
        logic [7:0] baddr;
        logic b2a;
        logic va;
        logic vb;
        logic vid;
        logic done;
    } xfer_res_t;

    // predictor state
    logic [2:0] mode_r [8];
    logic [4:0] flags_r [8];
    logic [7:0] bbase_r [8];
    logic [15:0] aptr_r [8];
    logic [7:0] abank_r [8];
    logic [15:0] count_r [8];
    logic [7:0] ibank_r [8];
    logic [15:0] tptr_r [8];
    logic [7:0] rep_r [8];
    logic [7:0] spare_r [8];
    logic [7:0] dma_mask, hdma_mask;
    logic [1:0] pat_idx;

    xfer_res_t expected_q [$];
    int errors = 0;
    int idle_pct = 14;
    bit rx_hold = 0;
    bit rx_long_hold = 0;
    int stall_cnt = 0;

    function automatic bit is_sys(logic [7:0] b);
        return b < 8'h40 || (b >= 8'h80 && b < 8'hc0);
    endfunction

    function automatic logic [1:0] pat_offset(logic [2:0] m, logic [1:0] p);
        case (m)
            3'd1, 3'd5: return {1'b0, p[0]};
            3'd3, 3'd7: return {1'b0, p[1]};
            3'd4: return p;
            default: return 2'd0;
        endcase
    endfunction

    task automatic reset_model();
        for (int i = 0; i < 8; i++) begin
            mode_r[i] = 3'd7; flags_r[i] = 5'h1f; bbase_r[i] = 8'hff;
            aptr_r[i] = 16'hffff; abank_r[i] = 8'hff; count_r[i] = 16'hffff;
            ibank_r[i] = 8'hff; tptr_r[i] = 16'hffff; rep_r[i] = 8'hff;
            spare_r[i] = 8'hff;
        end
        dma_mask = '0; hdma_mask = '0; pat_idx = '0;
    endtask

    function automatic xfer_res_t predict_cmd(logic [2:0] op, logic [6:0] ra, logic [7:0] wd);
        xfer_res_t r;
        int c;
        logic [3:0] idx;
        logic [15:0] aa;
        logic [7:0] bk, ba;
        r = '{default: '0};
        c = ra[6:4];
        idx = ra[3:0];
        case (op)
            dmacc_pkg::OP_READ: begin
                r.kind = dmacc_pkg::KIND_READ;
                case (idx)
                    4'h0: r.rdata = {flags_r[c], mode_r[c]};
                    4'h1: r.rdata = bbase_r[c];
                    4'h2: r.rdata = aptr_r[c][7:0];
                    4'h3: r.rdata = aptr_r[c][15:8];
                    4'h4: r.rdata = abank_r[c];
                    4'h5: r.rdata = count_r[c][7:0];
                    4'h6: r.rdata = count_r[c][15:8];
                    4'h7: r.rdata = ibank_r[c];
                    4'h8: r.rdata = tptr_r[c][7:0];
                    4'h9: r.rdata = tptr_r[c][15:8];
                    4'ha: r.rdata = rep_r[c];
                    4'hb, 4'hf: r.rdata = spare_r[c];
                    default: r.obus = 1'b1;
                endcase
            end
            dmacc_pkg::OP_WRITE: begin
                r.kind = dmacc_pkg::KIND_ACK;
                case (idx)
                    4'h0: begin mode_r[c] = wd[2:0]; flags_r[c] = wd[7:3]; end
                    4'h1: bbase_r[c] = wd;
                    4'h2: aptr_r[c][7:0] = wd;
                    4'h3: aptr_r[c][15:8] = wd;
                    4'h4: abank_r[c] = wd;
                    4'h5: count_r[c][7:0] = wd;
                    4'h6: count_r[c][15:8] = wd;
                    4'h7: ibank_r[c] = wd;
                    4'h8: tptr_r[c][7:0] = wd;
                    4'h9: tptr_r[c][15:8] = wd;
                    4'ha: rep_r[c] = wd;
                    4'hb, 4'hf: spare_r[c] = wd;
                    default: ;
                endcase
            end
            dmacc_pkg::OP_DMAEN: begin
                r.kind = dmacc_pkg::KIND_ACK; dma_mask = wd; pat_idx = '0;
            end
            dmacc_pkg::OP_HDMAEN: begin r.kind = dmacc_pkg::KIND_ACK; hdma_mask = wd; end
            dmacc_pkg::OP_STEP: begin
                c = 8;
                for (int i = 7; i >= 0; i--) if (dma_mask[i]) c = i;
                if (c == 8) r.kind = dmacc_pkg::KIND_IDLE;
                else begin
                    aa = aptr_r[c]; bk = abank_r[c];
                    ba = bbase_r[c] + pat_offset(mode_r[c], pat_idx);
                    r.kind = dmacc_pkg::KIND_XFER; r.ch = c[2:0]; r.aaddr = aa;
                    r.abank = bk; r.baddr = ba; r.b2a = flags_r[c][4];
                    r.va = !(is_sys(bk) && (aa == dmacc_pkg::ADDR_MDMAEN ||
                        aa == dmacc_pkg::ADDR_HDMAEN ||
                        (aa >= 16'h4300 && aa < dmacc_pkg::ADDR_DMAREGS) ||
                        (aa >= 16'h2100 && aa < dmacc_pkg::ADDR_PPU_END)));
                    r.vb = !(ba == 8'h80 && (bk == dmacc_pkg::BANK_WRAM || bk == 8'h7f ||
                        (is_sys(bk) && aa < dmacc_pkg::ADDR_WRAM_END)));
                    r.vid = (r.b2a ? r.va : r.vb) && (ba == dmacc_pkg::B_VRAM_DATA ||
                        ba == 8'h19 || ba == 8'h04 || ba == 8'h22);
                    if (!flags_r[c][0]) aptr_r[c] = flags_r[c][1] ? aa - 16'd1 : aa + 16'd1;
                    count_r[c] = count_r[c] - 16'd1;
                    if (count_r[c] == 0) begin
                        dma_mask[c] = 1'b0; pat_idx = '0; r.done = 1'b1;
                    end else pat_idx = pat_idx + 2'd1;
                end
            end
            default: r.kind = dmacc_pkg::KIND_ACK;
        endcase
        return r;
    endfunction

    task automatic send_cmd(logic [2:0] op, logic [6:0] ra, logic [7:0] wd);
        while (($urandom % 100) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, wd, ra};
        expected_q.push_back(predict_cmd(op, ra, wd));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver side
    always @(posedge aclk) begin
        if (rx_long_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom % 100) >= idle_pct;
    end

    always @(posedge aclk) begin
        xfer_res_t e;
        logic [55:0] d;
        logic [1:0] k;
        if (aresetn && m_tvalid && m_tready) begin
            d = m_tdata;
            k = m_tuser;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: %h %h", k, d);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (k != e.kind) begin
                    $error("result_kind exp %0d got %0d", e.kind, k); errors++; end
                if (d[7:0] != e.rdata) begin
                    $error("read_data exp %h got %h", e.rdata, d[7:0]); errors++; end
                if (d[8] != e.obus) begin
                    $error("unmapped_rd exp %0d got %0d", e.obus, d[8]); errors++; end
                if (d[11:9] != e.ch) begin
                    $error("channel_num exp %0d got %0d", e.ch, d[11:9]); errors++; end
                if (d[27:12] != e.aaddr) begin
                    $error("a_address exp %h got %h", e.aaddr, d[27:12]); errors++; end
                if (d[35:28] != e.abank) begin
                    $error("a_bank_out exp %h got %h", e.abank, d[35:28]); errors++; end
                if (d[43:36] != e.baddr) begin
                    $error("b_address exp %h got %h", e.baddr, d[43:36]); errors++; end
                if (d[44] != e.b2a) begin
                    $error("b_to_a exp %0d got %0d", e.b2a, d[44]); errors++; end
                if (d[45] != e.va) begin
                    $error("a_side_valid exp %0d got %0d", e.va, d[45]); errors++; end
                if (d[46] != e.vb) begin
                    $error("b_side_valid exp %0d got %0d", e.vb, d[46]); errors++; end
                if (d[47] != e.vid) begin
                    $error("video_port exp %0d got %0d", e.vid, d[47]); errors++; end
                if (d[48] != e.done) begin
                    $error("channel_done exp %0d got %0d", e.done, d[48]); errors++; end
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rx_long_hold) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 5000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_reset_values();
        for (int a = 0; a < 16; a++) send_cmd(dmacc_pkg::OP_READ, a[6:0], 8'h00);
        send_cmd(dmacc_pkg::OP_READ, 7'h7f, 8'h00);
        send_cmd(dmacc_pkg::OP_STEP, 7'h00, 8'h00);
    endtask

    task automatic test_directed();
        // channel 2: a-to-b, mode 4, b base 0x16, count 3 to cross the vram port
        send_cmd(dmacc_pkg::OP_WRITE, 7'h20, 8'h04);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h21, 8'h16);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h22, 8'h00);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h23, 8'h21);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h24, 8'h00);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h25, 8'h03);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h26, 8'h00);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h2c, 8'h55);
        send_cmd(dmacc_pkg::OP_HDMAEN, 7'h00, 8'hff);
        send_cmd(dmacc_pkg::OP_DMAEN, 7'h00, 8'h04);
        repeat (4) send_cmd(dmacc_pkg::OP_STEP, 7'h00, 8'h00);
        send_cmd(dmacc_pkg::OP_READ, 7'h25, 8'h00);
        send_cmd(dmacc_pkg::OP_READ, 7'h2d, 8'h00);
        send_cmd(OP_RSVD5, 7'h7f, 8'hff);
        send_cmd(OP_RSVD7, 7'h00, 8'h00);
        // zero count on channel 0 with wram bank and b address 0x80
        send_cmd(dmacc_pkg::OP_WRITE, 7'h00, 8'h80);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h01, 8'h80);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h04, 8'h7e);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h05, 8'h00);
        send_cmd(dmacc_pkg::OP_WRITE, 7'h06, 8'h00);
        send_cmd(dmacc_pkg::OP_DMAEN, 7'h00, 8'h01);
        send_cmd(dmacc_pkg::OP_STEP, 7'h00, 8'h00);
        send_cmd(dmacc_pkg::OP_READ, 7'h06, 8'h00);
        send_cmd(dmacc_pkg::OP_DMAEN, 7'h00, 8'h00);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                // well-formed channel setup with small counts
                c = $urandom_range(0, 7);
                send_cmd(dmacc_pkg::OP_WRITE, {c[2:0], 4'h0}, pick_byte());
                send_cmd(dmacc_pkg::OP_WRITE, {c[2:0], 4'h1}, pick_byte());
                send_cmd(dmacc_pkg::OP_WRITE, {c[2:0], 4'h2}, pick_byte());
                send_cmd(dmacc_pkg::OP_WRITE, {c[2:0], 4'h3}, pick_byte());
                send_cmd(dmacc_pkg::OP_WRITE, {c[2:0], 4'h4}, pick_byte());
                send_cmd(dmacc_pkg::OP_WRITE, {c[2:0], 4'h5}, 8'($urandom_range(0, 12)));
                send_cmd(dmacc_pkg::OP_WRITE, {c[2:0], 4'h6}, 8'h00);
                send_cmd(dmacc_pkg::OP_DMAEN, 7'h00,
                         8'($urandom_range(0, 255)) | (8'h1 << c[2:0]));
            end
            case ($urandom_range(0, 9))
                0, 1: send_cmd(dmacc_pkg::OP_READ, 7'($urandom_range(0, 127)), 8'h00);
                2, 3: send_cmd(dmacc_pkg::OP_WRITE, 7'($urandom_range(0, 127)), pick_byte());
                4: send_cmd(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                            pick_byte());
                default: send_cmd(dmacc_pkg::OP_STEP, 7'($urandom_range(0, 127)),
                                  pick_byte());
            endcase
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_long_hold = 1;
                repeat (200) @(posedge aclk);
                rx_long_hold = 0;
            end
            test_random(60);
        join
    endtask

    initial begin
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_directed();
        test_backpressure();
        idle_pct = 0;
        test_random(200);
        idle_pct = 14;
        test_random(550);
        wait_drain();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
